### design/julia_escape_time_pixel_assert.svh
// ---------------------------------------------------------------------------
// julia escape time pixel assertion macros
// clocked on i_clk, disabled while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH

// same-cycle implication
`define JETP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("julia escape time pixel assertion failed");

// next-cycle implication
`define JETP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("julia escape time pixel assertion failed");

`endif

### design/jetp_pkg.sv
// ---------------------------------------------------------------------------
// jetp_pkg
// shared constants, types and helpers of the julia escape time pixel block
// ---------------------------------------------------------------------------
`default_nettype none

package jetp_pkg;

    localparam int IMAGE_SIDE  = 1024;
    localparam int FRAC_BITS   = 28;
    localparam int COORD_W     = 10;
    localparam int PLANE_W     = 32;
    localparam int COUNT_W     = 16;
    localparam int STEP_W      = 31;
    localparam int PROD_W      = 2 * PLANE_W;
    localparam int START_W     = COORD_W + STEP_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 40;

    // coordinate reduction, side is a power of two
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'(IMAGE_SIDE - 1);

    // |z|^2 > 4 with 2*FRAC_BITS fraction bits
    localparam logic [PROD_W-1:0] ESCAPE_BOUND = PROD_W'(4) << (2 * FRAC_BITS);

    localparam logic signed [PROD_W-1:0] PLANE_MAX = PROD_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] PLANE_MIN = PROD_W'(64'shFFFF_FFFF_8000_0000);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONST_REAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONST_IMAG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 3'd5;

    // reset values
    localparam logic signed [PLANE_W-1:0] RST_CONST_REAL  = 32'sd0;
    localparam logic signed [PLANE_W-1:0] RST_CONST_IMAG  = 32'sd0;
    localparam logic [COUNT_W-1:0]        RST_ITER_LIMIT  = 16'd100;
    localparam logic [STEP_W-1:0]         RST_PIXEL_STEP  = 31'd1342177;
    localparam logic signed [PLANE_W-1:0] RST_ORIGIN_REAL = -32'sd536870912;
    localparam logic signed [PLANE_W-1:0] RST_ORIGIN_IMAG = -32'sd536870912;

    typedef struct packed {
        logic signed [PLANE_W-1:0] const_real;
        logic signed [PLANE_W-1:0] const_imag;
        logic [COUNT_W-1:0]        iter_limit;
        logic [STEP_W-1:0]         pixel_step;
        logic signed [PLANE_W-1:0] origin_real;
        logic signed [PLANE_W-1:0] origin_imag;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic start_mul;
        logic start_add;
        logic square;
        logic step;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        logic escaped;
        logic at_limit;
    } t_dp_status;

    function automatic logic signed [PLANE_W-1:0] sat_plane(input logic signed [PROD_W-1:0] v);
        logic signed [PLANE_W-1:0] res;
        if (v > PLANE_MAX) begin
            res = PLANE_MAX[PLANE_W-1:0];
        end else if (v < PLANE_MIN) begin
            res = PLANE_MIN[PLANE_W-1:0];
        end else begin
            res = v[PLANE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### design/jetp_regs.sv
// ---------------------------------------------------------------------------
// jetp_regs
// configuration register file written through the cfg channel
// ---------------------------------------------------------------------------
`default_nettype none

module jetp_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [jetp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [jetp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output jetp_pkg::t_cfg                      o_cfg
);
    import jetp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CONST_REAL:  n_cfg.const_real  = i_cfg_data;
                REG_CONST_IMAG:  n_cfg.const_imag  = i_cfg_data;
                REG_ITER_LIMIT:  n_cfg.iter_limit  = i_cfg_data[COUNT_W-1:0];
                REG_PIXEL_STEP:  n_cfg.pixel_step  = i_cfg_data[STEP_W-1:0];
                REG_ORIGIN_REAL: n_cfg.origin_real = i_cfg_data;
                REG_ORIGIN_IMAG: n_cfg.origin_imag = i_cfg_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.const_real  <= RST_CONST_REAL;
            r_cfg.const_imag  <= RST_CONST_IMAG;
            r_cfg.iter_limit  <= RST_ITER_LIMIT;
            r_cfg.pixel_step  <= RST_PIXEL_STEP;
            r_cfg.origin_real <= RST_ORIGIN_REAL;
            r_cfg.origin_imag <= RST_ORIGIN_IMAG;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/jetp_ctrl.sv
// ---------------------------------------------------------------------------
// jetp_ctrl
// sequencer for start point, square and test steps, and output slot
// ---------------------------------------------------------------------------
`default_nettype none

module jetp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire jetp_pkg::t_dp_status i_status,
    output jetp_pkg::t_dp_cmd   o_cmd
);
    import jetp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_TEST = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.start_mul = 1'b1;
                n_state         = S_ADD;
            end
            S_ADD: begin
                o_cmd.start_add = 1'b1;
                n_state         = S_SQ;
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state      = S_TEST;
            end
            S_TEST: begin
                if (i_status.at_limit || i_status.escaped) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_SQ;
                end
            end
            S_OUT: begin
                if (w_slot_free) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### design/jetp_dp.sv
// ---------------------------------------------------------------------------
// jetp_dp
// fixed point datapath: start point, squares, escape test, update, result
// ---------------------------------------------------------------------------
`default_nettype none

module jetp_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire jetp_pkg::t_cfg               i_cfg,
    input  wire jetp_pkg::t_dp_cmd            i_cmd,
    output jetp_pkg::t_dp_status              o_status,
    input  wire logic [jetp_pkg::COORD_W-1:0] i_col,
    input  wire logic [jetp_pkg::COORD_W-1:0] i_row,
    output logic [jetp_pkg::COORD_W-1:0]      o_col,
    output logic [jetp_pkg::COORD_W-1:0]      o_row,
    output logic [jetp_pkg::COUNT_W-1:0]      o_count,
    output logic                              o_inside
);
    import jetp_pkg::*;

    logic [COORD_W-1:0]        r_col;
    logic [COORD_W-1:0]        r_row;
    logic [START_W-1:0]        r_prod_re;
    logic [START_W-1:0]        r_prod_im;
    logic signed [PLANE_W-1:0] r_zr;
    logic signed [PLANE_W-1:0] r_zi;
    logic signed [PROD_W-1:0]  r_rr;
    logic signed [PROD_W-1:0]  r_ii;
    logic signed [PROD_W-1:0]  r_ri;
    logic [COUNT_W-1:0]        r_count;
    logic [COORD_W-1:0]        r_out_col;
    logic [COORD_W-1:0]        r_out_row;
    logic [COUNT_W-1:0]        r_out_count;
    logic                      r_out_inside;

    logic signed [PROD_W-1:0]  w_rr;
    logic signed [PROD_W-1:0]  w_ii;
    logic signed [PROD_W-1:0]  w_ri;
    logic [PROD_W-1:0]         w_mag;
    logic signed [PROD_W-1:0]  w_re;
    logic signed [PROD_W-1:0]  w_im;
    logic signed [PROD_W-1:0]  w_start_re;
    logic signed [PROD_W-1:0]  w_start_im;
    logic                      w_at_limit;

    assign w_rr = r_zr * r_zr;
    assign w_ii = r_zi * r_zi;
    assign w_ri = r_zr * r_zi;

    // both squares are non-negative, their sum fits unsigned
    assign w_mag = $unsigned(r_rr) + $unsigned(r_ii);

    assign w_re = (r_rr - r_ii) >>> FRAC_BITS;
    assign w_im = r_ri >>> (FRAC_BITS - 1);

    assign w_start_re = PROD_W'(i_cfg.origin_real) + $signed({{(PROD_W - START_W){1'b0}}, r_prod_re});
    assign w_start_im = PROD_W'(i_cfg.origin_imag) + $signed({{(PROD_W - START_W){1'b0}}, r_prod_im});

    assign w_at_limit = (r_count >= i_cfg.iter_limit);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col <= i_col & COORD_MASK;
            r_row <= i_row & COORD_MASK;
        end
        if (i_cmd.start_mul) begin
            r_prod_re <= START_W'(r_col) * START_W'(i_cfg.pixel_step);
            r_prod_im <= START_W'(r_row) * START_W'(i_cfg.pixel_step);
        end
        if (i_cmd.start_add) begin
            r_zr <= sat_plane(w_start_re);
            r_zi <= sat_plane(w_start_im);
        end else if (i_cmd.step) begin
            r_zr <= sat_plane(w_re + PROD_W'(i_cfg.const_real));
            r_zi <= sat_plane(w_im + PROD_W'(i_cfg.const_imag));
        end
        if (i_cmd.square) begin
            r_rr <= w_rr;
            r_ii <= w_ii;
            r_ri <= w_ri;
        end
        if (i_cmd.capture) begin
            r_out_col    <= r_col;
            r_out_row    <= r_row;
            r_out_count  <= r_count;
            r_out_inside <= w_at_limit;
        end
    end

    // iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_count <= r_count + COUNT_W'(1);
        end
    end

    assign o_status.escaped  = (w_mag > ESCAPE_BOUND);
    assign o_status.at_limit = w_at_limit;

    assign o_col    = r_out_col;
    assign o_row    = r_out_row;
    assign o_count  = r_out_count;
    assign o_inside = r_out_inside;

endmodule

`default_nettype wire

### design/julia_escape_time_pixel.sv
// one pixel at a time: a new pixel is taken only once the last one is captured; one square
//   step and one test/update step per iteration through three 32x32 multipliers
// a finished result waits in the output register while the next pixel is taken,
//   an unread result holds the next capture until the output slot frees
// synchronous active-low reset clears control state and loads register defaults
// ---------------------------------------------------------------------------
// julia_escape_time_pixel
// julia set escape time count for one pixel in q4.28 fixed point
// ---------------------------------------------------------------------------
`default_nettype none
`include "julia_escape_time_pixel_assert.svh"

module julia_escape_time_pixel (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // pixel_col [9:0], pixel_row [19:10], zero fill above
    input  wire logic [jetp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // out_col [9:0], out_row [19:10], iteration_count [35:20], zero fill above
    output logic [jetp_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // inside_set [0]
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [jetp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [jetp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import jetp_pkg::*;

    t_cfg               w_cfg;
    t_dp_cmd            w_cmd;
    t_dp_status         w_status;
    logic [COORD_W-1:0] w_out_col;
    logic [COORD_W-1:0] w_out_row;
    logic [COUNT_W-1:0] w_out_count;

    assign o_cfg_ready = 1'b1;

    jetp_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    jetp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    jetp_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_col    (s_axis_tdata[COORD_W-1:0]),
        .i_row    (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .o_col    (w_out_col),
        .o_row    (w_out_row),
        .o_count  (w_out_count),
        .o_inside (m_axis_tuser)
    );

    assign m_axis_tdata = {{(M_TDATA_W - 2*COORD_W - COUNT_W){1'b0}},
                           w_out_count, w_out_row, w_out_col};

    // busy once a pixel is taken
    `JETP_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // a held result is never overwritten
    `JETP_ASSERT_SAME(a_no_overwrite, m_axis_tvalid && !m_axis_tready, !w_cmd.capture)
    // at most one datapath command per cycle
    `JETP_ASSERT_SAME(a_one_command, 1'b1, $onehot0(w_cmd))

endmodule

`default_nettype wire

### tb/tb_julia_escape_time_pixel.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_julia_escape_time_pixel
// Drives pixel coordinates into the julia escape time block and checks each
// result against a fixed-point escape-time predictor. A short table of
// directed pixels covers reset settings, iteration limits of zero, one and
// the maximum, saturating starts and constants, and writes to unused
// register indexes. A random part follows, several register settings with
// random pixels. Both stream sides idle at random, quiet at the end.
// ---------------------------------------------------------------------------

module tb_julia_escape_time_pixel;

    import jetp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic [63:0] ESC_BOUND = 64'd4 << (2 * FRAC_BITS);
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PIXELS = 62;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COUNT_W-1:0] count;
        logic               in_set;
    } pixel_result_t;

    typedef struct {
        bit                 new_setting;
        t_cfg               setting;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        bit                 known;
        logic [COUNT_W-1:0] count;
        logic               in_set;
    } probe_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_cfg          plane_cfg;
    pixel_result_t pending_pixels[$];
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    bit            calm = 1'b0;

    julia_escape_time_pixel u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [63:0] clamp_q428(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) begin
            return 64'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            return -64'sh8000_0000;
        end
        return v;
    endfunction

    function automatic pixel_result_t escape_time(input t_cfg c, input logic [COORD_W-1:0] col,
                                                  input logic [COORD_W-1:0] row);
        logic signed [63:0] zr, zi, cr, ci, nr;
        logic [63:0]        mag;
        int unsigned        n;
        pixel_result_t      res;
        cr = 64'($signed(c.const_real));
        ci = 64'($signed(c.const_imag));
        zr = clamp_q428(64'($signed(c.origin_real)) + $signed({54'd0, col})
                        * $signed({33'd0, c.pixel_step}));
        zi = clamp_q428(64'($signed(c.origin_imag)) + $signed({54'd0, row})
                        * $signed({33'd0, c.pixel_step}));
        n = 0;
        mag = $unsigned(zr * zr) + $unsigned(zi * zi);
        while (n < c.iter_limit && mag <= ESC_BOUND) begin
            nr = clamp_q428(((zr * zr - zi * zi) >>> FRAC_BITS) + cr);
            zi = clamp_q428(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
            zr = nr;
            n++;
            mag = $unsigned(zr * zr) + $unsigned(zi * zi);
        end
        res.col = col;
        res.row = row;
        res.count = n[COUNT_W-1:0];
        res.in_set = (n == c.iter_limit);
        return res;
    endfunction

    function automatic t_cfg make_setting(input logic [31:0] cr, input logic [31:0] ci,
                                          input logic [15:0] lim, input logic [30:0] stp,
                                          input logic [31:0] orr, input logic [31:0] ori);
        t_cfg c;
        c.const_real = cr;
        c.const_imag = ci;
        c.iter_limit = lim;
        c.pixel_step = stp;
        c.origin_real = orr;
        c.origin_imag = ori;
        return c;
    endfunction

    function automatic t_cfg random_setting();
        t_cfg c;
        c.const_real = ($urandom_range(0, 7) == 0) ? $urandom
                     : int'($urandom_range(0, 1 << 30)) - (1 << 29);
        c.const_imag = ($urandom_range(0, 7) == 0) ? $urandom
                     : int'($urandom_range(0, 1 << 30)) - (1 << 29);
        c.iter_limit = COUNT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3)
                                                            : $urandom_range(1, 250));
        c.pixel_step = STEP_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                           : $urandom_range(0, 2 * 1342177));
        c.origin_real = ($urandom_range(0, 7) == 0) ? $urandom : -int'($urandom_range(0, 1 << 29));
        c.origin_imag = ($urandom_range(0, 7) == 0) ? $urandom : -int'($urandom_range(0, 1 << 29));
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_CONST_REAL:  plane_cfg.const_real = data;
            REG_CONST_IMAG:  plane_cfg.const_imag = data;
            REG_ITER_LIMIT:  plane_cfg.iter_limit = data[COUNT_W-1:0];
            REG_PIXEL_STEP:  plane_cfg.pixel_step = data[STEP_W-1:0];
            REG_ORIGIN_REAL: plane_cfg.origin_real = data;
            REG_ORIGIN_IMAG: plane_cfg.origin_imag = data;
            default: ;
        endcase
    endtask

    // block must be idle: every pending result drained first
    task automatic program_setting(input t_cfg c);
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        write_reg(REG_CONST_REAL, c.const_real);
        write_reg(REG_CONST_IMAG, c.const_imag);
        write_reg(REG_ITER_LIMIT, {16'($urandom), c.iter_limit});
        write_reg(REG_PIXEL_STEP, {1'($urandom), c.pixel_step});
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_ORIGIN_REAL, c.origin_real);
        write_reg(REG_ORIGIN_IMAG, c.origin_imag);
        write_reg(REG_SPARE_B, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                              input bit use_typed, input pixel_result_t typed);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tdata  <= {4'd0, row, col};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_pixels.push_back(use_typed ? typed : escape_time(plane_cfg, col, row));
    endtask

    // result side stalls
    initial begin
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        pixel_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata[9:0] !== want.col) begin
                    $display("%0t: out_col expected %0d actual %0d",
                             $time, want.col, m_axis_tdata[9:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[19:10] !== want.row) begin
                    $display("%0t: out_row expected %0d actual %0d",
                             $time, want.row, m_axis_tdata[19:10]);
                    mismatch_count++;
                end
                if (m_axis_tdata[35:20] !== want.count) begin
                    $display("%0t: iteration_count expected %0d actual %0d (pixel %0d,%0d)",
                             $time, want.count, m_axis_tdata[35:20], want.col, want.row);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.in_set) begin
                    $display("%0t: inside_set expected %b actual %b (pixel %0d,%0d)",
                             $time, want.in_set, m_axis_tuser, want.col, want.row);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_cfg          s_reset, s_lim0, s_lim1, s_cext, s_cext2, s_sat, s_deep, s_julia;
        probe_row_t    rows[$];
        pixel_result_t typed;
        t_cfg          rnd;

        s_reset = make_setting(RST_CONST_REAL, RST_CONST_IMAG, RST_ITER_LIMIT, RST_PIXEL_STEP,
                               RST_ORIGIN_REAL, RST_ORIGIN_IMAG);
        s_lim0  = make_setting(0, 0, 16'd0, RST_PIXEL_STEP, RST_ORIGIN_REAL, RST_ORIGIN_IMAG);
        s_lim1  = make_setting(0, 0, 16'd1, RST_PIXEL_STEP, RST_ORIGIN_REAL, RST_ORIGIN_IMAG);
        s_cext  = make_setting(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 31'd0, 32'd0, 32'd0);
        s_cext2 = make_setting(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 31'd0, 32'd0, 32'd0);
        s_sat   = make_setting(0, 0, 16'hFFFF, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        s_deep  = make_setting(0, 0, 16'hFFFF, 31'd0, 32'd0, 32'd0);
        s_julia = make_setting(-32'sd214748365, 32'sd41875931, 16'd200, RST_PIXEL_STEP,
                               RST_ORIGIN_REAL, RST_ORIGIN_IMAG);

        // reset settings: far corner escapes at once, center sits at zero
        rows.push_back('{1'b0, s_reset, 10'd0, 10'd0, 1'b1, 16'd0, 1'b0});
        rows.push_back('{1'b0, s_reset, 10'd1023, 10'd1023, 1'b1, 16'd0, 1'b0});
        rows.push_back('{1'b0, s_reset, 10'd400, 10'd400, 1'b1, 16'd100, 1'b1});
        // zero limit counts as inside even for an escaping start
        rows.push_back('{1'b1, s_lim0, 10'd400, 10'd400, 1'b1, 16'd0, 1'b1});
        rows.push_back('{1'b0, s_lim0, 10'd0, 10'd0, 1'b1, 16'd0, 1'b1});
        rows.push_back('{1'b1, s_lim1, 10'd0, 10'd0, 1'b1, 16'd0, 1'b0});
        rows.push_back('{1'b0, s_lim1, 10'd400, 10'd400, 1'b1, 16'd1, 1'b1});
        // extreme constants from a zero start escape after one step
        rows.push_back('{1'b1, s_cext, 10'd0, 10'd1023, 1'b1, 16'd1, 1'b0});
        rows.push_back('{1'b0, s_cext, 10'd1023, 10'd0, 1'b1, 16'd1, 1'b0});
        rows.push_back('{1'b1, s_cext2, 10'd1023, 10'd1023, 1'b1, 16'd1, 1'b0});
        // saturating starts
        rows.push_back('{1'b1, s_sat, 10'd0, 10'd0, 1'b1, 16'd0, 1'b0});
        rows.push_back('{1'b0, s_sat, 10'd1023, 10'd1023, 1'b1, 16'd0, 1'b0});
        rows.push_back('{1'b0, s_sat, 10'd1, 10'd0, 1'b1, 16'd0, 1'b0});
        // fixed point at zero runs to the largest limit
        rows.push_back('{1'b1, s_deep, 10'd512, 10'd700, 1'b1, 16'hFFFF, 1'b1});
        rows.push_back('{1'b1, s_julia, 10'd400, 10'd400, 1'b0, 16'd0, 1'b0});
        rows.push_back('{1'b0, s_julia, 10'h2AA, 10'h155, 1'b0, 16'd0, 1'b0});
        rows.push_back('{1'b0, s_julia, 10'h155, 10'h2AA, 1'b0, 16'd0, 1'b0});
        rows.push_back('{1'b0, s_julia, 10'd300, 10'd420, 1'b0, 16'd0, 1'b0});
        rows.push_back('{1'b0, s_julia, 10'd512, 10'd512, 1'b0, 16'd0, 1'b0});
        rows.push_back('{1'b0, s_julia, 10'd1023, 10'd0, 1'b0, 16'd0, 1'b0});
        rows.push_back('{1'b0, s_julia, 10'd0, 10'd1023, 1'b0, 16'd0, 1'b0});

        plane_cfg = s_reset;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].new_setting) begin
                program_setting(rows[i].setting);
            end
            typed = '{rows[i].col, rows[i].row, rows[i].count, rows[i].in_set};
            send_pixel(rows[i].col, rows[i].row, rows[i].known, typed);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            rnd = random_setting();
            program_setting(rnd);
            if (p == RANDOM_PHASES - 1) begin
                calm = 1'b1;
            end
            for (int k = 0; k < PHASE_PIXELS; k++) begin
                send_pixel(COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)),
                           1'b0, typed);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (2 * plane_cfg.iter_limit + 10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/jetp_pkg.sv
design/jetp_regs.sv
design/jetp_ctrl.sv
design/jetp_dp.sv
design/julia_escape_time_pixel.sv
tb/tb_julia_escape_time_pixel.sv
